/* hdl/gfwpa_pkg.sv */
// package: shared constants and codes for the g-force window peak alarm
`default_nettype none
package gfwpa_pkg;

  // window of stored magnitudes
  localparam int WINDOW_DEPTH = 16;
  localparam int RING_AW      = $clog2(WINDOW_DEPTH);

  // field widths
  localparam int OP_W      = 2;
  localparam int ACCEL_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int MAG_W     = 16;
  localparam int TOTAL_W   = 20;
  localparam int LEVEL_W   = 2;
  localparam int CNT_W     = 16;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  // exact window sum and the width used to saturate it
  localparam int SUM_W  = MAG_W + RING_AW;
  localparam int WIDE_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

  // shared multiplier and square root datapath
  localparam int MUL_B_W    = TOTAL_W;
  localparam int PROD_W     = THR_W + MUL_B_W;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int REM_W      = MAG_W + 2;
  localparam int SQRT_STEPS = MAG_W;
  localparam int STEP_W     = $clog2(SQRT_STEPS);

  // opcodes
  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_WARN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ALARM = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_WARN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_ALARM = 4'd3;

  // configuration reset values
  localparam logic [THR_W-1:0] FORCE_WARN_RST  = 16'd384;
  localparam logic [THR_W-1:0] FORCE_ALARM_RST = 16'd512;
  localparam logic [THR_W-1:0] ANGLE_WARN_RST  = 16'd7680;
  localparam logic [THR_W-1:0] ANGLE_ALARM_RST = 16'd15360;

  // grading levels
  localparam logic [LEVEL_W-1:0] LVL_NONE  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ALARM = 2'd2;

endpackage
`default_nettype wire

/* hdl/gfwpa_in_if.sv */
// interface: input item channel
`default_nettype none
interface gfwpa_in_if;
  import gfwpa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;
  logic [ANGLE_W-1:0]        tilt_angle;

  modport source (output valid, opcode, accel_x, accel_y, accel_z, tilt_angle,
                  input ready);
  modport sink   (input valid, opcode, accel_x, accel_y, accel_z, tilt_angle,
                  output ready);
endinterface
`default_nettype wire

/* hdl/gfwpa_out_if.sv */
// interface: result item channel
`default_nettype none
interface gfwpa_out_if;
  import gfwpa_pkg::*;

  logic               valid;
  logic               ready;
  logic [MAG_W-1:0]   magnitude;
  logic [TOTAL_W-1:0] window_total;
  logic [TOTAL_W-1:0] peak_total;
  logic               buzzer_on;
  logic [LEVEL_W-1:0] force_level;
  logic [LEVEL_W-1:0] angle_level;
  logic [CNT_W-1:0]   sample_total;

  modport source (output valid, magnitude, window_total, peak_total, buzzer_on,
                  force_level, angle_level, sample_total, input ready);
  modport sink   (input valid, magnitude, window_total, peak_total, buzzer_on,
                  force_level, angle_level, sample_total, output ready);
endinterface
`default_nettype wire

/* hdl/gfwpa_cfg_if.sv */
// interface: configuration write channel
`default_nettype none
interface gfwpa_cfg_if;
  import gfwpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

/* hdl/gforce_window_peak_alarm.sv */
// top level: windowed acceleration magnitude peak and tilt alarm
// sample item: 3 squaring passes on the shared multiplier, 16 square-root
//   iterations, ring update, peak update, then output load
// update item: two ratio products, then output load; calibrate and unused opcode:
//   output load only; in_ready stays low until the result loads, so no new item
//   is taken while one is in flight or a waiting result holds the output register
// sync active-low reset: default thresholds, state cleared, ready right after reset
`default_nettype none
module gforce_window_peak_alarm (
  input wire logic     clk,
  input wire logic     rst_n,
  gfwpa_in_if.sink     in_ch,
  gfwpa_out_if.source  out_ch,
  gfwpa_cfg_if.sink    cfg_ch
);
  import gfwpa_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQZ  = 4'd3;
  localparam logic [3:0] S_ROOT = 4'd4;
  localparam logic [3:0] S_RING = 4'd5;
  localparam logic [3:0] S_PEAK = 4'd6;
  localparam logic [3:0] S_FW   = 4'd7;
  localparam logic [3:0] S_FA   = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]              state_r;
  logic [THR_W-1:0]        force_warn_r, force_alarm_r, angle_warn_r, angle_alarm_r;
  logic [RING_AW-1:0]      pos_r;
  logic [WINDOW_DEPTH-1:0] ring_vld_r;
  logic [SUM_W-1:0]        total_r;
  logic [TOTAL_W-1:0]      peak_r, base_r;
  logic                    buzz_r;
  logic [CNT_W-1:0]        count_r;
  logic                    out_valid_r;

  // datapath registers
  logic [ACCEL_W-1:0]  ax_r, ay_r, az_r;
  logic [ANGLE_W-1:0]  tilt_r;
  logic [RAD_W-1:0]    acc_r, rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [MAG_W-1:0]    root_r;
  logic [STEP_W-1:0]   step_r;
  logic                fw_r;
  logic [MAG_W-1:0]    res_mag_r;
  logic [TOTAL_W-1:0]  res_peak_r;
  logic [LEVEL_W-1:0]  res_flev_r, res_alev_r;

  // output payload registers
  logic [MAG_W-1:0]    out_mag_r;
  logic [TOTAL_W-1:0]  out_total_r, out_peak_r;
  logic                out_buzz_r;
  logic [LEVEL_W-1:0]  out_flev_r, out_alev_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic                in_fire, cfg_fire, out_load;
  logic [THR_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  logic                ratio_ge;
  logic [WIDE_W-1:0]   total_wide;
  logic [TOTAL_W-1:0]  total_sat;
  logic [TOTAL_W-1:0]  total_sat_nxt;
  logic [SUM_W-1:0]    total_nxt;
  logic [MAG_W-1:0]    ram_rdata, old_mag;
  logic [REM_W:0]      rem_shift, trial;
  logic                trial_ok;
  logic [RAD_W-1:0]    sq_sum;
  logic [ACCEL_W-1:0]  abs_x, abs_y, abs_z;

  // handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // absolute values of the axes
  assign abs_x = in_ch.accel_x[ACCEL_W-1] ? (ACCEL_W'(0) - in_ch.accel_x) : in_ch.accel_x;
  assign abs_y = in_ch.accel_y[ACCEL_W-1] ? (ACCEL_W'(0) - in_ch.accel_y) : in_ch.accel_y;
  assign abs_z = in_ch.accel_z[ACCEL_W-1] ? (ACCEL_W'(0) - in_ch.accel_z) : in_ch.accel_z;

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_SQX: begin
        mul_a = ax_r;
        mul_b = MUL_B_W'(ax_r);
      end
      S_SQY: begin
        mul_a = ay_r;
        mul_b = MUL_B_W'(ay_r);
      end
      S_SQZ: begin
        mul_a = az_r;
        mul_b = MUL_B_W'(az_r);
      end
      S_FW: begin
        mul_a = force_warn_r;
        mul_b = base_r;
      end
      S_FA: begin
        mul_a = force_alarm_r;
        mul_b = base_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sq_sum   = acc_r + prod[RAD_W-1:0];
  assign ratio_ge = PROD_W'({peak_r, 8'd0}) >= prod;

  // square root step: one result bit per cycle
  assign rem_shift = {rem_r[REM_W-2:0], rad_r[RAD_W-1 -: 2]};
  assign trial     = (REM_W + 1)'({root_r, 2'b01});
  assign trial_ok  = rem_shift >= trial;

  // saturated view of the window sum
  assign total_wide = WIDE_W'(total_r);
  assign total_sat  = (total_wide > WIDE_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                        : total_wide[TOTAL_W-1:0];

  // ring update: drop the oldest magnitude, add the new one
  assign old_mag       = ring_vld_r[pos_r] ? ram_rdata : '0;
  assign total_nxt     = total_r - SUM_W'(old_mag) + SUM_W'(root_r);
  assign total_sat_nxt = total_sat;

  gfwpa_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_RING),
    .addr  (pos_r),
    .wdata (root_r),
    .rdata (ram_rdata)
  );

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      force_warn_r  <= FORCE_WARN_RST;
      force_alarm_r <= FORCE_ALARM_RST;
      angle_warn_r  <= ANGLE_WARN_RST;
      angle_alarm_r <= ANGLE_ALARM_RST;
      pos_r         <= '0;
      ring_vld_r    <= '0;
      total_r       <= '0;
      peak_r        <= '0;
      base_r        <= '0;
      buzz_r        <= 1'b0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_fire) begin
        case (cfg_ch.reg_index)
          CFG_FORCE_WARN:  force_warn_r  <= cfg_ch.wdata;
          CFG_FORCE_ALARM: force_alarm_r <= cfg_ch.wdata;
          CFG_ANGLE_WARN:  angle_warn_r  <= cfg_ch.wdata;
          CFG_ANGLE_ALARM: angle_alarm_r <= cfg_ch.wdata;
          default: ;
        endcase
      end

      // output valid
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.opcode)
              OP_SAMPLE: state_r <= S_SQX;
              OP_CALIBRATE: begin
                base_r  <= total_sat;
                state_r <= S_DONE;
              end
              OP_UPDATE: state_r <= S_FW;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SQX:  state_r <= S_SQY;
        S_SQY:  state_r <= S_SQZ;
        S_SQZ:  state_r <= S_ROOT;
        S_ROOT: begin
          if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
            state_r <= S_RING;
          end
        end
        S_RING: begin
          total_r           <= total_nxt;
          ring_vld_r[pos_r] <= 1'b1;
          pos_r   <= (pos_r == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;
          if (count_r != CNT_MAX) begin
            count_r <= count_r + 1'b1;
          end
          state_r <= S_PEAK;
        end
        S_PEAK: begin
          if (total_sat_nxt > peak_r) begin
            peak_r <= total_sat_nxt;
          end
          state_r <= S_DONE;
        end
        S_FW: state_r <= S_FA;
        S_FA: begin
          buzz_r  <= fw_r || (tilt_r >= angle_warn_r);
          peak_r  <= base_r;
          count_r <= '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ax_r       <= abs_x;
          ay_r       <= abs_y;
          az_r       <= abs_z;
          tilt_r     <= in_ch.tilt_angle;
          res_mag_r  <= '0;
          res_peak_r <= peak_r;
          res_flev_r <= LVL_NONE;
          res_alev_r <= LVL_NONE;
        end
      end
      S_SQX: acc_r <= prod[RAD_W-1:0];
      S_SQY: acc_r <= sq_sum;
      S_SQZ: begin
        rad_r  <= sq_sum;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      S_ROOT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
        if (trial_ok) begin
          rem_r  <= REM_W'(rem_shift - trial);
          root_r <= {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r  <= REM_W'(rem_shift);
          root_r <= {root_r[MAG_W-2:0], 1'b0};
        end
      end
      S_RING: res_mag_r <= root_r;
      S_PEAK: res_peak_r <= (total_sat_nxt > peak_r) ? total_sat_nxt : peak_r;
      S_FW:   fw_r <= ratio_ge;
      S_FA: begin
        res_flev_r <= ratio_ge ? LVL_ALARM : (fw_r ? LVL_WARN : LVL_NONE);
        res_alev_r <= (tilt_r >= angle_alarm_r) ? LVL_ALARM
                    : ((tilt_r >= angle_warn_r) ? LVL_WARN : LVL_NONE);
      end
      default: ;
    endcase

    // result register
    if (out_load) begin
      out_mag_r   <= res_mag_r;
      out_total_r <= total_sat;
      out_peak_r  <= res_peak_r;
      out_buzz_r  <= buzz_r;
      out_flev_r  <= res_flev_r;
      out_alev_r  <= res_alev_r;
      out_cnt_r   <= count_r;
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.magnitude    = out_mag_r;
  assign out_ch.window_total = out_total_r;
  assign out_ch.peak_total   = out_peak_r;
  assign out_ch.buzzer_on    = out_buzz_r;
  assign out_ch.force_level  = out_flev_r;
  assign out_ch.angle_level  = out_alev_r;
  assign out_ch.sample_total = out_cnt_r;

endmodule
`default_nettype wire

/* hdl/gfwpa_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module gfwpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* hdl/gfwpa_chk.sv */
// checker: port-level properties of the alarm block, bound to the top level
`default_nettype none
module gfwpa_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [gfwpa_pkg::MAG_W-1:0]       out_magnitude,
  input wire logic [gfwpa_pkg::TOTAL_W-1:0]     out_window_total,
  input wire logic [gfwpa_pkg::LEVEL_W-1:0]     out_force_level,
  input wire logic [gfwpa_pkg::LEVEL_W-1:0]     out_angle_level,
  input wire logic [gfwpa_pkg::CNT_W-1:0]       out_sample_total
);
  import gfwpa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_total))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // only update items grade, only sample items give a magnitude
  a_mag_vs_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_magnitude != '0 |->
      out_force_level == LVL_NONE && out_angle_level == LVL_NONE)
    else $error("magnitude and level on the same result");

  // a graded result comes from an update, which clears the sample count
  a_level_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_force_level != LVL_NONE || out_angle_level != LVL_NONE) |->
      out_sample_total == '0)
    else $error("sample count not cleared on update");

endmodule

bind gforce_window_peak_alarm gfwpa_chk u_gfwpa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_magnitude    (out_ch.magnitude),
  .out_window_total (out_ch.window_total),
  .out_force_level  (out_ch.force_level),
  .out_angle_level  (out_ch.angle_level),
  .out_sample_total (out_ch.sample_total)
);
`default_nettype wire

/* verif/tb_gforce_window_peak_alarm.sv */
// testbench: random and directed item traffic against a cycle-free predictor of the alarm block
`timescale 1ns / 1ps
module tb_gforce_window_peak_alarm;
  import gfwpa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int CFG_INTERVAL   = 250;
  localparam int TAIL_ITEMS     = 120;
  localparam int CFG_SETTLE     = 4;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // one queued operation: a sensor item or a register write
  typedef struct packed {
    bit                        is_cfg;
    logic [OP_W-1:0]           opcode;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic [ANGLE_W-1:0]        tilt_angle;
    logic [CFG_IDX_W-1:0]      reg_index;
    logic [CFG_DAT_W-1:0]      wdata;
  } reading_t;

  // one alarm report as the block emits it
  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [TOTAL_W-1:0] window_total;
    logic [TOTAL_W-1:0] peak_total;
    logic               buzzer_on;
    logic [LEVEL_W-1:0] force_level;
    logic [LEVEL_W-1:0] angle_level;
    logic [CNT_W-1:0]   sample_total;
  } report_t;

  logic clk;
  logic rst_n;

  gfwpa_in_if  in_ch();
  gfwpa_out_if out_ch();
  gfwpa_cfg_if cfg_ch();

  gforce_window_peak_alarm u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  reading_t reading_q[$];
  report_t  report_q[$];
  int       fail_count   = 0;
  int       items_sent   = 0;
  int       results_seen = 0;
  int       item_count   = 0;
  bit       tail_phase   = 1'b0;

  // thresholds as planned while filling the queue, for picking tilts near them
  logic [THR_W-1:0] plan_angle_warn  = ANGLE_WARN_RST;
  logic [THR_W-1:0] plan_angle_alarm = ANGLE_ALARM_RST;

  // predictor state
  logic [MAG_W-1:0]   mag_ring [WINDOW_DEPTH];
  int unsigned        ring_slot;
  longint unsigned    window_sum;
  logic [TOTAL_W-1:0] peak_hold;
  logic [TOTAL_W-1:0] base_hold;
  bit                 buzz_state;
  logic [CNT_W-1:0]   sample_cnt;
  logic [THR_W-1:0]   thr_force_warn;
  logic [THR_W-1:0]   thr_force_alarm;
  logic [THR_W-1:0]   thr_angle_warn;
  logic [THR_W-1:0]   thr_angle_alarm;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // reset and known input levels from time zero
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_SAMPLE;
    in_ch.accel_x     = '0;
    in_ch.accel_y     = '0;
    in_ch.accel_z     = '0;
    in_ch.tilt_angle  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = CFG_FORCE_WARN;
    cfg_ch.wdata      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned axis_sq(logic signed [ACCEL_W-1:0] a);
    longint s;
    s = a;
    if (s < 0) s = -s;
    return s * s;
  endfunction

  // bit-by-bit floor square root
  function automatic logic [MAG_W-1:0] floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root[MAG_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] window_view();
    return (window_sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : window_sum[TOTAL_W-1:0];
  endfunction

  // peak/base against an 8.8 threshold, no division
  function automatic bit ratio_met(logic [THR_W-1:0] thr);
    return 64'(peak_hold) * 64'd256 >= 64'(thr) * 64'(base_hold);
  endfunction

  function automatic report_t forecast_report(reading_t rd);
    report_t         r;
    longint unsigned energy;
    bit              fw_hit;
    bit              fa_hit;
    r = '0;
    r.peak_total = peak_hold;
    case (rd.opcode)
      OP_SAMPLE: begin
        energy = axis_sq(rd.accel_x) + axis_sq(rd.accel_y) + axis_sq(rd.accel_z);
        r.magnitude = floor_sqrt(energy);
        window_sum = window_sum - mag_ring[ring_slot] + r.magnitude;
        mag_ring[ring_slot] = r.magnitude;
        ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
        if (window_view() > peak_hold) peak_hold = window_view();
        r.peak_total = peak_hold;
        if (sample_cnt != CNT_MAX) sample_cnt++;
      end
      OP_CALIBRATE: begin
        base_hold = window_view();
      end
      OP_UPDATE: begin
        fw_hit = ratio_met(thr_force_warn);
        fa_hit = ratio_met(thr_force_alarm);
        r.force_level = fa_hit ? LVL_ALARM : (fw_hit ? LVL_WARN : LVL_NONE);
        r.angle_level = (rd.tilt_angle >= thr_angle_alarm) ? LVL_ALARM :
                        (rd.tilt_angle >= thr_angle_warn) ? LVL_WARN : LVL_NONE;
        buzz_state = fw_hit || (rd.tilt_angle >= thr_angle_warn);
        peak_hold  = base_hold;
        sample_cnt = '0;
      end
      default: begin
        // unused opcode leaves every state alone
      end
    endcase
    r.window_total = window_view();
    r.buzzer_on    = buzz_state;
    r.sample_total = sample_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------- queue filling

  function automatic logic signed [ACCEL_W-1:0] rand_axis(int unsigned amp);
    int v;
    v = int'($urandom_range(2 * amp)) - int'(amp);
    if (v > 32767) v = 32767;
    return v[ACCEL_W-1:0];
  endfunction

  task automatic push_item(logic [OP_W-1:0] op, logic signed [ACCEL_W-1:0] x,
                           logic signed [ACCEL_W-1:0] y, logic signed [ACCEL_W-1:0] z,
                           logic [ANGLE_W-1:0] tilt);
    reading_t rd;
    rd = '0;
    rd.opcode     = op;
    rd.accel_x    = x;
    rd.accel_y    = y;
    rd.accel_z    = z;
    rd.tilt_angle = tilt;
    reading_q.push_back(rd);
    item_count++;
  endtask

  task automatic push_sample(int unsigned amp);
    push_item(OP_SAMPLE, rand_axis(amp), rand_axis(amp), rand_axis(amp),
              ANGLE_W'($urandom()));
  endtask

  task automatic push_op(logic [OP_W-1:0] op, logic [ANGLE_W-1:0] tilt);
    push_item(op, ACCEL_W'($urandom()), ACCEL_W'($urandom()), ACCEL_W'($urandom()), tilt);
  endtask

  task automatic push_thresholds(logic [THR_W-1:0] fw, logic [THR_W-1:0] fa,
                                 logic [THR_W-1:0] aw, logic [THR_W-1:0] aa);
    reading_t             rd;
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [CFG_DAT_W-1:0] vals [4];
    idx  = '{CFG_FORCE_WARN, CFG_FORCE_ALARM, CFG_ANGLE_WARN, CFG_ANGLE_ALARM};
    vals = '{fw, fa, aw, aa};
    for (int i = 0; i < 4; i++) begin
      rd = '0;
      rd.is_cfg    = 1'b1;
      rd.reg_index = idx[i];
      rd.wdata     = vals[i];
      reading_q.push_back(rd);
    end
    plan_angle_warn  = aw;
    plan_angle_alarm = aa;
  endtask

  // stimulus, then wait for the block to drain and report
  initial begin
    int unsigned      amp;
    int unsigned      surge;
    int unsigned      cfg_phase;
    int unsigned      next_cfg_at;
    int unsigned      random_end;
    logic [THR_W-1:0] fw, fa, aw, aa;
    logic [ANGLE_W-1:0] tilt;

    // zero base on the first update: both force thresholds count as reached
    push_op(OP_UPDATE, '0);
    // magnitude extremes and sign handling
    push_item(OP_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF);
    push_item(OP_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767, '0);
    push_item(OP_SAMPLE, '0, '0, '0, 16'hFFFF);
    push_item(OP_SAMPLE, 16'sd1, -16'sd1, '0, '0);
    push_item(OP_SAMPLE, 16'sd32767, -16'sd32768, -16'sd1, '0);
    push_op(OP_CALIBRATE, 16'hFFFF);
    // unused opcode only reports state
    push_item(OP_UNUSED, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF);
    push_item(OP_SAMPLE, 16'sd3, 16'sd4, '0, '0);
    push_item(OP_SAMPLE, -16'sd20000, 16'sd20000, 16'sd100, '0);
    // tilt grading around the default thresholds
    push_op(OP_UPDATE, ANGLE_WARN_RST - 16'd1);
    push_op(OP_UPDATE, ANGLE_WARN_RST);
    push_op(OP_UPDATE, ANGLE_ALARM_RST);
    push_op(OP_UPDATE, 16'd46080);
    push_op(OP_UPDATE, 16'hFFFF);
    // a partial window of smaller readings, then grading against the base
    repeat (6) push_sample(2000);
    push_op(OP_UPDATE, 16'd100);
    push_item(OP_UNUSED, '0, '0, '0, '0);

    random_end  = item_count + RANDOM_ITEMS;
    next_cfg_at = item_count;
    cfg_phase   = 0;
    while (item_count < random_end) begin
      // new threshold set between phases: zeros, all ones, defaults, then random
      if (item_count >= next_cfg_at) begin
        case (cfg_phase)
          0: push_thresholds('0, '0, '0, '0);
          1: push_thresholds('1, '1, '1, '1);
          2: push_thresholds(FORCE_WARN_RST, FORCE_ALARM_RST, ANGLE_WARN_RST,
                             ANGLE_ALARM_RST);
          default: begin
            case ($urandom_range(2))
              0: begin
                fw = THR_W'($urandom());
                fa = THR_W'($urandom());
                aw = THR_W'($urandom());
                aa = THR_W'($urandom());
              end
              1: begin
                fw = THR_W'($urandom_range(256, 640));
                fa = THR_W'($urandom_range(fw, 1024));
                aw = THR_W'($urandom_range(0, 46080));
                aa = THR_W'($urandom_range(aw, 46080));
              end
              default: begin
                // warn set above alarm
                fa = THR_W'($urandom_range(256, 640));
                fw = THR_W'($urandom_range(fa, 1024));
                aa = THR_W'($urandom_range(0, 46080));
                aw = THR_W'($urandom_range(aa, 46080));
              end
            endcase
            push_thresholds(fw, fa, aw, aa);
          end
        endcase
        cfg_phase++;
        next_cfg_at += CFG_INTERVAL;
      end

      if ($urandom_range(99) < 82) begin
        // a session: usually settle the window and calibrate, then take a burst and grade it
        case ($urandom_range(2))
          0:       amp = $urandom_range(0, 64);
          1:       amp = $urandom_range(64, 4096);
          default: amp = $urandom_range(4096, 32768);
        endcase
        if ($urandom_range(99) < 75) begin
          repeat ($urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 4)) push_sample(amp);
          push_op(OP_CALIBRATE, ANGLE_W'($urandom()));
        end
        surge = amp * $urandom_range(30, 300) / 100;
        if (surge > 32768) surge = 32768;
        repeat ($urandom_range(1, 24)) push_sample(($urandom_range(99) < 30) ? amp : surge);
        case ($urandom_range(4))
          0:       tilt = plan_angle_warn - 16'd1;
          1:       tilt = plan_angle_warn;
          2:       tilt = plan_angle_alarm;
          3:       tilt = ANGLE_W'($urandom_range(0, 46080));
          default: tilt = ANGLE_W'($urandom());
        endcase
        push_op(OP_UPDATE, tilt);
      end else begin
        // noise: any opcode, any field values
        repeat ($urandom_range(1, 6))
          push_item(OP_W'($urandom_range(3)), ACCEL_W'($urandom()), ACCEL_W'($urandom()),
                    ACCEL_W'($urandom()), ANGLE_W'($urandom()));
      end
    end

    wait (rst_n === 1'b1);
    do @(posedge clk);
    while (reading_q.size() != 0 || in_ch.valid || cfg_ch.valid || report_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_gforce_window_peak_alarm passed");
    end else begin
      $display("tb_gforce_window_peak_alarm failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  int unsigned gap_left    = 0;
  int unsigned settle_cnt  = 0;
  int unsigned idle_pct    = 0;
  int unsigned launch_cnt  = 0;

  always @(posedge clk) begin
    reading_t next_rd;
    bit       in_hold;
    bit       cfg_hold;
    bit       launch_item;
    bit       launch_cfg;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      gap_left     = 0;
      settle_cnt   = 0;
    end else begin
      launch_item = 1'b0;
      launch_cfg  = 1'b0;
      next_rd     = '0;
      if (in_ch.valid && in_ch.ready) items_sent++;
      in_hold  = in_ch.valid && !in_ch.ready;
      cfg_hold = cfg_ch.valid && !cfg_ch.ready;

      if (!in_hold && !cfg_hold && reading_q.size() != 0) begin
        if (reading_q[0].is_cfg) begin
          // registers change only once every report is back
          if (items_sent == results_seen) settle_cnt++;
          else settle_cnt = 0;
          if (settle_cnt > CFG_SETTLE) begin
            next_rd    = reading_q.pop_front();
            launch_cfg = 1'b1;
            settle_cnt = 0;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          next_rd     = reading_q.pop_front();
          launch_item = 1'b1;
          // idle density changes every few dozen items, none near the end
          launch_cnt++;
          if (launch_cnt % 48 == 0) begin
            case ($urandom_range(2))
              0:       idle_pct = 0;
              1:       idle_pct = 15;
              default: idle_pct = 50;
            endcase
          end
          if (reading_q.size() >= TAIL_ITEMS && $urandom_range(99) < idle_pct)
            gap_left = $urandom_range(1, 14);
        end
      end

      if (launch_item) begin
        in_ch.opcode     <= next_rd.opcode;
        in_ch.accel_x    <= next_rd.accel_x;
        in_ch.accel_y    <= next_rd.accel_y;
        in_ch.accel_z    <= next_rd.accel_z;
        in_ch.tilt_angle <= next_rd.tilt_angle;
      end
      if (launch_cfg) begin
        cfg_ch.reg_index <= next_rd.reg_index;
        cfg_ch.wdata     <= next_rd.wdata;
      end
      in_ch.valid  <= in_hold || launch_item;
      cfg_ch.valid <= cfg_hold || launch_cfg;
      tail_phase   <= reading_q.size() < TAIL_ITEMS;
    end
  end

  // ---------------------------------------------------------------- result stalls

  int unsigned hold_left   = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_cycle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    = 0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 256 == 0) begin
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (tail_phase) begin
        hold_left = 0;
        out_ch.ready <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        hold_left = $urandom_range(13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    reading_t taken;
    report_t  want;
    if (!rst_n) begin
      foreach (mag_ring[i]) mag_ring[i] = '0;
      ring_slot       = 0;
      window_sum      = 0;
      peak_hold       = '0;
      base_hold       = '0;
      buzz_state      = 1'b0;
      sample_cnt      = '0;
      thr_force_warn  = FORCE_WARN_RST;
      thr_force_alarm = FORCE_ALARM_RST;
      thr_angle_warn  = ANGLE_WARN_RST;
      thr_angle_alarm = ANGLE_ALARM_RST;
      results_seen   <= 0;
    end else begin
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_FORCE_WARN:  thr_force_warn  = cfg_ch.wdata;
          CFG_FORCE_ALARM: thr_force_alarm = cfg_ch.wdata;
          CFG_ANGLE_WARN:  thr_angle_warn  = cfg_ch.wdata;
          CFG_ANGLE_ALARM: thr_angle_alarm = cfg_ch.wdata;
          default: ;
        endcase
      end

      // compare each report with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (report_q.size() == 0) begin
          $error("report item arrived with nothing expected");
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("magnitude",    want.magnitude,    out_ch.magnitude);
          check_field("window_total", want.window_total, out_ch.window_total);
          check_field("peak_total",   want.peak_total,   out_ch.peak_total);
          check_field("buzzer_on",    want.buzzer_on,    out_ch.buzzer_on);
          check_field("force_level",  want.force_level,  out_ch.force_level);
          check_field("angle_level",  want.angle_level,  out_ch.angle_level);
          check_field("sample_total", want.sample_total, out_ch.sample_total);
        end
      end

      // predict from the item as accepted on the wire
      if (in_ch.valid && in_ch.ready) begin
        taken            = '0;
        taken.opcode     = in_ch.opcode;
        taken.accel_x    = in_ch.accel_x;
        taken.accel_y    = in_ch.accel_y;
        taken.accel_z    = in_ch.accel_z;
        taken.tilt_angle = in_ch.tilt_angle;
        report_q.push_back(forecast_report(taken));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_gforce_window_peak_alarm failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/gfwpa_pkg.sv
hdl/gfwpa_in_if.sv
hdl/gfwpa_out_if.sv
hdl/gfwpa_cfg_if.sv
hdl/gfwpa_ram.sv
hdl/gforce_window_peak_alarm.sv
hdl/gfwpa_chk.sv
verif/tb_gforce_window_peak_alarm.sv
